### sv/spq_pkg.sv
// spq_pkg: shared types and codes for the sorted priority queue
// request and result words, controller commands and status, state encoding
// no dependencies
package spq_pkg;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic        opcode;
        logic [31:0] entry_key;
        logic [31:0] entry_value;
    } req_t;

    typedef struct packed {
        logic [31:0] popped_value;
        logic [31:0] head_value;
        logic [4:0]  entry_count;
        logic        is_empty;
        status_t     status;
    } rsp_t;

    typedef enum logic {
        CTRL_IDLE = 1'b0,
        CTRL_HOLD = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic    load;
        logic    push;
        logic    pop;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } dp_stat_t;

endpackage

### sv/sorted_priority_queue_core.sv
// sorted_priority_queue_core: top level of the sorted priority queue
// joins the handshake controller and the cell datapath
// depends on spq_pkg, spq_ctrl, spq_dp
//
// usage
//   req channel (req_valid/req_ready/req): one request per handshake, push
//   (key, value) or pop head. rsp channel (rsp_valid/rsp_ready/rsp): one
//   result per request with popped value, head value, count, empty and status.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): sets descending order; always
//   ready, write only while no request is in flight.
// latency: the result is valid the cycle after the request is taken
// throughput: one request per cycle while rsp_ready is high; all cells compare
//   the new key in parallel and shift in one step
// stalls: the result register holds while rsp_ready is low; a new request is
//   taken only in a cycle where that result leaves
// reset: queue empty, ascending order, no result pending
// push to a full queue is dropped with status full; pop on empty reports
//   status empty and leaves the queue unchanged
module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_data
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    assign cfg_ready = 1'b1;

    spq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_opcode (req.opcode),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .dp_stat    (dp_stat),
        .dp_cmd     (dp_cmd)
    );

    spq_dp #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .req       (req),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat),
        .rsp       (rsp)
    );

endmodule

### sv/spq_ctrl.sv
// spq_ctrl: request/result handshake controller of the sorted priority queue
// decodes each request into datapath commands and tracks the result register
// depends on spq_pkg
module spq_ctrl
    import spq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  logic     req_opcode,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    input  dp_stat_t dp_stat,
    output dp_cmd_t  dp_cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTRL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        rsp_valid     = 1'b0;
        req_ready     = 1'b1;
        accept        = 1'b0;
        dp_cmd        = '0;
        dp_cmd.status = STATUS_OK;
        unique case (state_reg)
            CTRL_IDLE:
            begin
                req_ready = 1'b1;
                rsp_valid = 1'b0;
            end
            CTRL_HOLD:
            begin
                req_ready = rsp_ready;
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase
        accept = req_valid && req_ready;
        if (accept)
        begin
            state_next  = CTRL_HOLD;
            dp_cmd.load = 1'b1;
            if (req_opcode == OP_PUSH)
            begin
                if (dp_stat.full)
                begin
                    dp_cmd.status = STATUS_FULL;
                end
                else
                begin
                    dp_cmd.push = 1'b1;
                end
            end
            else
            begin
                if (dp_stat.empty)
                begin
                    dp_cmd.status = STATUS_EMPTY;
                end
                else
                begin
                    dp_cmd.pop = 1'b1;
                end
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.push |-> !dp_stat.full)
        else $error("push issued on full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.pop |-> !dp_stat.empty)
        else $error("pop issued on empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> rsp_valid)
        else $error("accepted request produced no result");

endmodule

### sv/spq_dp.sv
// spq_dp: shift-register cell array, occupancy count and result register
// inserts by parallel key compare, pops by shifting toward the head
// depends on spq_pkg
module spq_dp
    import spq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_write,
    input  logic     cfg_data,
    input  req_t     req,
    input  dp_cmd_t  dp_cmd,
    output dp_stat_t dp_stat,
    output rsp_t     rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [KEY_BITS-1:0]   key_reg [CAPACITY];
    logic [VALUE_BITS-1:0] val_reg [CAPACITY];
    logic [KEY_BITS-1:0]   key_up  [CAPACITY];
    logic [VALUE_BITS-1:0] val_up  [CAPACITY];
    logic [KEY_BITS-1:0]   key_dn  [CAPACITY];
    logic [VALUE_BITS-1:0] val_dn  [CAPACITY];
    logic [CAPACITY-1:0]   ins;
    logic [CAPACITY-1:0]   ahead;
    logic [CAPACITY-1:0]   at_pos;
    logic [CAPACITY-1:0]   shift_dn;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  desc_reg;
    logic [63:0]           key_wide;
    logic [63:0]           val_wide;
    logic [KEY_BITS-1:0]   new_key;
    logic [VALUE_BITS-1:0] new_val;
    logic [VALUE_BITS-1:0] head_next;
    logic [63:0]           head_wide;
    logic [63:0]           pop_wide;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;

    assign key_wide = {32'd0, req.entry_key};
    assign val_wide = {32'd0, req.entry_value};
    assign new_key  = key_wide[KEY_BITS-1:0];
    assign new_val  = val_wide[VALUE_BITS-1:0];

    assign dp_stat.full  = (count_reg == CNT_W'(CAPACITY));
    assign dp_stat.empty = (count_reg == '0);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi < CAPACITY - 1)
            begin : g_up
                assign key_up[gi] = key_reg[gi+1];
                assign val_up[gi] = val_reg[gi+1];
            end
            else
            begin : g_last
                assign key_up[gi] = key_reg[gi];
                assign val_up[gi] = val_reg[gi];
            end

            if (gi == 0)
            begin : g_first
                assign ahead[gi]  = 1'b0;
                assign key_dn[gi] = key_reg[gi];
                assign val_dn[gi] = val_reg[gi];
            end
            else
            begin : g_rest
                assign ahead[gi]  = |ins[gi-1:0];
                assign key_dn[gi] = key_reg[gi-1];
                assign val_dn[gi] = val_reg[gi-1];
            end

            assign ins[gi] = (CNT_W'(gi) < count_reg) &&
                             (desc_reg ? (new_key > key_reg[gi]) : (new_key < key_reg[gi]));
            assign at_pos[gi]   = !ahead[gi] && (ins[gi] || (count_reg == CNT_W'(gi)));
            assign shift_dn[gi] = ahead[gi] && (CNT_W'(gi) <= count_reg);

            always_ff @(posedge clk)
            begin
                if (dp_cmd.push)
                begin
                    if (at_pos[gi])
                    begin
                        key_reg[gi] <= new_key;
                        val_reg[gi] <= new_val;
                    end
                    else if (shift_dn[gi])
                    begin
                        key_reg[gi] <= key_dn[gi];
                        val_reg[gi] <= val_dn[gi];
                    end
                end
                else if (dp_cmd.pop)
                begin
                    key_reg[gi] <= key_up[gi];
                    val_reg[gi] <= val_up[gi];
                end
            end
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        head_next  = val_reg[0];
        if (dp_cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
            head_next  = at_pos[0] ? new_val : val_reg[0];
        end
        else if (dp_cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
            head_next  = val_up[0];
        end
    end

    always_comb
    begin
        head_wide = 64'(head_next);
        pop_wide  = 64'(val_reg[0]);
        rsp_next.popped_value = dp_cmd.pop ? pop_wide[31:0] : 32'd0;
        rsp_next.head_value   = (count_next != '0) ? head_wide[31:0] : 32'd0;
        rsp_next.entry_count  = 5'(count_next);
        rsp_next.is_empty     = (count_next == '0);
        rsp_next.status       = dp_cmd.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            desc_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_write)
            begin
                desc_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(dp_cmd.push && dp_cmd.pop))
        else $error("push and pop in one cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.push |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not grow occupancy");

endmodule
